[hw/rtl/bmf_pkg.sv]
// Shared types and constants for the RGB box mean filter.
`default_nettype none
package bmf_pkg;

    localparam int CH_W       = 16;
    localparam int PIX_W      = 3 * CH_W;
    localparam int RADIUS_W   = 4;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FLUSH,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/bmf_mem.sv]
// Pixel row store: one write port, one read port, registered read data.
`default_nettype none
module bmf_mem #(
    parameter int DEPTH = 18432,
    parameter int AW    = 15
) (
    input  wire                        clk,
    input  wire                        we,
    input  wire [AW-1:0]               waddr,
    input  wire [bmf_pkg::PIX_W-1:0]   wdata,
    input  wire                        re,
    input  wire [AW-1:0]               raddr,
    output logic [bmf_pkg::PIX_W-1:0]  rdata
);

    logic [bmf_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/bmf_div.sv]
// Three-lane restoring divider sharing one divisor, one quotient bit per cycle.
`default_nettype none
module bmf_div #(
    parameter int DW = 25,
    parameter int VW = 9
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    input  wire [2:0][DW-1:0]                   dividend,
    input  wire [VW-1:0]                        divisor,
    output logic                                done,
    output logic [2:0][bmf_pkg::CH_W-1:0]       quotient
);

    localparam int KW = $clog2(DW + 1);

    logic [2:0][DW-1:0] quo_reg, quo_next;
    logic [2:0][VW-1:0] rem_reg, rem_next;
    logic [VW-1:0]      dsr_reg;
    logic [KW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    always_comb
    begin
        logic [VW:0] shifted;
        for (int i = 0; i < 3; i++)
        begin
            shifted = {rem_reg[i], quo_reg[i][DW-1]};
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next[i] = VW'(shifted - {1'b0, dsr_reg});
                quo_next[i] = {quo_reg[i][DW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = VW'(shifted);
                quo_next[i] = {quo_reg[i][DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= KW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - KW'(1);
                if (cnt_reg == KW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quotient[i] = quo_reg[i][bmf_pkg::CH_W-1:0];
        end
    end

    assign done = done_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without a division");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0)) else $error("busy with empty count");
`endif

endmodule
`default_nettype wire

[hw/rtl/box_mean_filter_rgb_top.sv]
// Box mean filter top: frame counters, window scan sequencer and output register.
// Latency: a result leaves (radius*width+radius) transactions after its pixel, drain
// transactions flush the tail. One transaction at a time: one that yields no result goes back
// to idle after its check, else its window is read through the single row-store read port (one
// pixel per cycle) and divided by the bit-serial divider over the full sum width (25 by default).
// Reset: counters clear, radius/width/height return to 2/640/480; the row store is not cleared.
`default_nettype none
module box_mean_filter_rgb_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 8
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [bmf_pkg::PIX_W-1:0]           s_tdata,   // in_red, in_green, in_blue
    input  wire [0:0]                          s_tuser,   // op
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [bmf_pkg::PIX_W-1:0]          m_tdata,   // out_red, out_green, out_blue
    output logic                               m_tlast,
    input  wire                                cfg_we,
    input  wire [bmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [bmf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int NW    = $clog2(WIN + 1);
    localparam int CNTW  = $clog2(WIN * WIN + 1);
    localparam int SW    = $clog2(WIN * WIN * 65535 + 1);
    localparam int TW    = $clog2(MAX_WIDTH * bmf_pkg::MAX_HEIGHT + 1);
    localparam int HW    = bmf_pkg::HEIGHT_W;
    localparam int CH    = bmf_pkg::CH_W;

    bmf_pkg::state_t state_reg, state_next;

    logic [bmf_pkg::RADIUS_W-1:0] radius_reg;
    logic [bmf_pkg::WIDTH_W-1:0]  width_reg;
    logic [HW-1:0]                height_reg;

    logic [CW-1:0]               in_col_reg, out_col_reg;
    logic [bmf_pkg::ROW_W-1:0]   in_row_reg, out_row_reg;
    logic [AW-1:0]               in_base_reg, out_base_reg;
    logic [TW-1:0]               in_count_reg, out_count_reg;
    logic                        frame_in_reg;
    logic [TW-1:0]               total_reg, lag_reg;

    logic [AW-1:0]  rowb_reg;
    logic [CW-1:0]  col0_reg;
    logic [NW-1:0]  xi_reg, yi_reg, nr_reg, nc_reg;
    logic [CNTW-1:0] cnt_reg;
    logic           rd_pend_reg;
    logic [2:0][SW-1:0] sum_reg;

    logic                 m_valid_reg;
    logic [bmf_pkg::PIX_W-1:0] m_data_reg;
    logic                 m_last_reg;

    logic [RW-1:0] rr_eff;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic accept, pix_we, emit, scan_last, out_load, out_last;
    logic [AW-1:0] rd_addr;
    logic [bmf_pkg::PIX_W-1:0] rd_data;
    logic div_start, div_done;
    logic [2:0][CH-1:0] div_q;

    // Window bounds for the next result
    logic [RW-1:0] dr0, dr1, dc0, dc1;
    logic [HW-1:0] hm1r;
    logic [WW-1:0] wm1c;
    logic [AW:0]   up_off, base0;

    always_comb
    begin
        rr_eff = (radius_reg > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (width_reg > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == '0)
            h_eff = HW'(1);
        else if (height_reg > bmf_pkg::MAX_HEIGHT)
            h_eff = HW'(bmf_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    always_comb
    begin
        dr0  = (out_row_reg > rr_eff) ? rr_eff : RW'(out_row_reg);
        hm1r = h_eff - HW'(1) - HW'(out_row_reg);
        dr1  = (hm1r > rr_eff) ? rr_eff : RW'(hm1r);
        dc0  = (out_col_reg > rr_eff) ? rr_eff : RW'(out_col_reg);
        wm1c = w_eff - WW'(1) - WW'(out_col_reg);
        dc1  = (wm1c > rr_eff) ? rr_eff : RW'(wm1c);
        up_off = (AW+1)'(dr0 * MAX_WIDTH);
        if ({1'b0, out_base_reg} >= up_off)
            base0 = {1'b0, out_base_reg} - up_off;
        else
            base0 = {1'b0, out_base_reg} + (AW+1)'(DEPTH) - up_off;
    end

    assign accept    = s_tvalid && s_tready;
    assign pix_we    = accept && (s_tuser[0] == bmf_pkg::OP_PIXEL) && !frame_in_reg;
    assign emit      = (out_count_reg < total_reg) &&
                       (({1'b0, in_count_reg} > ({1'b0, out_count_reg} + {1'b0, lag_reg}))
                        || frame_in_reg);
    assign scan_last = (xi_reg == nc_reg - NW'(1)) && (yi_reg == nr_reg - NW'(1));
    assign out_load  = (state_reg == bmf_pkg::ST_OUT) && (!m_valid_reg || m_tready);
    assign out_last  = (out_count_reg + TW'(1)) == total_reg;
    assign rd_addr   = rowb_reg + AW'(col0_reg) + AW'(xi_reg);
    assign div_start = (state_reg == bmf_pkg::ST_START);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmf_pkg::ST_IDLE:  if (accept) state_next = bmf_pkg::ST_CHECK;
            bmf_pkg::ST_CHECK: state_next = emit ? bmf_pkg::ST_SCAN : bmf_pkg::ST_IDLE;
            bmf_pkg::ST_SCAN:  if (scan_last) state_next = bmf_pkg::ST_FLUSH;
            bmf_pkg::ST_FLUSH: state_next = bmf_pkg::ST_START;
            bmf_pkg::ST_START: state_next = bmf_pkg::ST_DIV;
            bmf_pkg::ST_DIV:   if (div_done) state_next = bmf_pkg::ST_OUT;
            bmf_pkg::ST_OUT:   if (out_load) state_next = bmf_pkg::ST_IDLE;
            default:           state_next = bmf_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready = 1'b0;
        unique case (state_reg)
            bmf_pkg::ST_IDLE: s_tready = 1'b1;
            default:          s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmf_pkg::ST_IDLE;
            radius_reg    <= bmf_pkg::RADIUS_W'(2);
            width_reg     <= bmf_pkg::WIDTH_W'(640);
            height_reg    <= HW'(480);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_base_reg   <= '0;
            in_count_reg  <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_base_reg  <= '0;
            out_count_reg <= '0;
            frame_in_reg  <= 1'b0;
            total_reg     <= '0;
            lag_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == bmf_pkg::ST_SCAN);

            if (accept)
            begin
                total_reg <= TW'(w_eff * h_eff);
                lag_reg   <= TW'(rr_eff * w_eff + rr_eff);
            end

            if (pix_we)
            begin
                in_count_reg <= in_count_reg + TW'(1);
                if (WW'(in_col_reg) == w_eff - WW'(1))
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + bmf_pkg::ROW_W'(1);
                    in_base_reg <= (in_base_reg == AW'(DEPTH - MAX_WIDTH)) ? '0
                                   : in_base_reg + AW'(MAX_WIDTH);
                    if ((HW'(in_row_reg) + HW'(1)) >= h_eff)
                        frame_in_reg <= 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end

            if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;

            if (out_load)
            begin
                m_valid_reg   <= 1'b1;
                out_count_reg <= out_count_reg + TW'(1);
                if (WW'(out_col_reg) == w_eff - WW'(1))
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + bmf_pkg::ROW_W'(1);
                    out_base_reg <= (out_base_reg == AW'(DEPTH - MAX_WIDTH)) ? '0
                                    : out_base_reg + AW'(MAX_WIDTH);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end

            // Frame restart: after the last result, or on any register write
            if ((out_load && out_last) ||
                (cfg_we && (cfg_index == bmf_pkg::REG_RADIUS ||
                            cfg_index == bmf_pkg::REG_WIDTH ||
                            cfg_index == bmf_pkg::REG_HEIGHT)))
            begin
                in_col_reg    <= '0;
                in_row_reg    <= '0;
                in_base_reg   <= '0;
                in_count_reg  <= '0;
                out_col_reg   <= '0;
                out_row_reg   <= '0;
                out_base_reg  <= '0;
                out_count_reg <= '0;
                frame_in_reg  <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    bmf_pkg::REG_RADIUS: radius_reg <= cfg_data[bmf_pkg::RADIUS_W-1:0];
                    bmf_pkg::REG_WIDTH:  width_reg  <= cfg_data[bmf_pkg::WIDTH_W-1:0];
                    bmf_pkg::REG_HEIGHT: height_reg <= cfg_data[HW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Scan datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == bmf_pkg::ST_CHECK)
        begin
            rowb_reg <= AW'(base0);
            col0_reg <= out_col_reg - CW'(dc0);
            nr_reg   <= NW'(dr0) + NW'(dr1) + NW'(1);
            nc_reg   <= NW'(dc0) + NW'(dc1) + NW'(1);
            xi_reg   <= '0;
            yi_reg   <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            if (state_reg == bmf_pkg::ST_SCAN)
            begin
                if (xi_reg == nc_reg - NW'(1))
                begin
                    xi_reg <= '0;
                    yi_reg <= yi_reg + NW'(1);
                    rowb_reg <= (rowb_reg == AW'(DEPTH - MAX_WIDTH)) ? '0
                                : rowb_reg + AW'(MAX_WIDTH);
                end
                else
                begin
                    xi_reg <= xi_reg + NW'(1);
                end
            end
            if (rd_pend_reg)
            begin
                for (int i = 0; i < 3; i++)
                    sum_reg[i] <= sum_reg[i] + SW'(rd_data[i*CH +: CH]);
            end
        end
        if (state_reg == bmf_pkg::ST_FLUSH)
            cnt_reg <= CNTW'(nr_reg * nc_reg);
        if (out_load)
        begin
            m_data_reg <= {div_q[2], div_q[1], div_q[0]};
            m_last_reg <= out_last;
        end
    end

    bmf_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (pix_we),
        .waddr (in_base_reg + AW'(in_col_reg)),
        .wdata (s_tdata),
        .re    (state_reg == bmf_pkg::ST_SCAN),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    bmf_div #(
        .DW (SW),
        .VW (CNTW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pix_we |-> (state_reg == bmf_pkg::ST_IDLE)) else $error("store write outside idle");
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == bmf_pkg::ST_DIV)) else $error("divider done out of turn");
    a_out_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmf_pkg::ST_SCAN) |-> (out_count_reg < in_count_reg))
        else $error("result ahead of input");
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmf_pkg::ST_SCAN) |-> (rd_addr < AW'(DEPTH - 1) || rd_addr == AW'(DEPTH - 1)))
        else $error("row store read out of range");
`endif

endmodule
`default_nettype wire
